// File: sv/hsv2rgb_pkg.sv
// ----------------------------------------------------------------------------
// hsv2rgb_pkg
// Shared widths, divider constants, sextant codes and stage records for the
// hsv to rgb converter pipeline.
// ----------------------------------------------------------------------------
package hsv2rgb_pkg;

   localparam int COLOR_BITS = 8;
   localparam int HUE_BITS   = 9;
   localparam int REM_BITS   = 6;
   localparam int SEXT_BITS  = 3;
   localparam int SEXTANT    = 60;
   localparam int HUE_WRAP   = 360;

   localparam logic [COLOR_BITS-1:0] FULL_SCALE = '1;

   // saturation times remainder, and full scale times sextant width
   localparam int SR_BITS   = COLOR_BITS + REM_BITS;
   // numerators before the divide by full scale (a) and by full scale * 60 (b, c)
   localparam int NUMA_BITS = 2 * COLOR_BITS;
   localparam int NUMB_BITS = 2 * COLOR_BITS + REM_BITS;

   localparam longint unsigned DEN_A = (64'd1 << COLOR_BITS) - 64'd1;
   localparam longint unsigned DEN_B = DEN_A * SEXTANT;

   // reciprocals, under-estimating the quotient by at most one
   localparam int MA_BITS = NUMA_BITS - COLOR_BITS + 1;
   localparam int MB_BITS = NUMB_BITS - COLOR_BITS - 4;
   localparam longint unsigned RECIP_A = (64'd1 << NUMA_BITS) / DEN_A;
   localparam longint unsigned RECIP_B = (64'd1 << NUMB_BITS) / DEN_B;

   localparam logic [SR_BITS-1:0] DEN_B_SR = SR_BITS'(DEN_B);

   typedef enum logic [SEXT_BITS-1:0] {
      SEXT_RED_YELLOW,
      SEXT_YELLOW_GREEN,
      SEXT_GREEN_CYAN,
      SEXT_CYAN_BLUE,
      SEXT_BLUE_MAGENTA,
      SEXT_MAGENTA_RED
   } sextant_type;

   typedef struct packed {
      logic                  gray;
      logic                  black;
      sextant_type           sextant;
      logic [REM_BITS-1:0]   rem;
      logic [COLOR_BITS-1:0] sat;
      logic [COLOR_BITS-1:0] bright;
   } dec_type;

   typedef struct packed {
      logic                  gray;
      logic                  black;
      sextant_type           sextant;
      logic [COLOR_BITS-1:0] bright;
      logic [COLOR_BITS-1:0] inv_sat;
      logic [SR_BITS-1:0]    sat_rem;
      logic [SR_BITS-1:0]    sat_crem;
   } prod_type;

   typedef struct packed {
      logic                  gray;
      logic                  black;
      sextant_type           sextant;
      logic [COLOR_BITS-1:0] bright;
      logic [NUMA_BITS-1:0]  num_a;
      logic [NUMB_BITS-1:0]  num_b;
      logic [NUMB_BITS-1:0]  num_c;
   } num_type;

   typedef struct packed {
      logic                  gray;
      logic                  black;
      sextant_type           sextant;
      logic [COLOR_BITS-1:0] bright;
      logic [NUMA_BITS-1:0]  num_a;
      logic [NUMB_BITS-1:0]  num_b;
      logic [NUMB_BITS-1:0]  num_c;
      logic [COLOR_BITS-1:0] est_a;
      logic [COLOR_BITS-1:0] est_b;
      logic [COLOR_BITS-1:0] est_c;
   } est_type;

endpackage

// File: sv/hsv2rgb_decode.sv
// ----------------------------------------------------------------------------
// hsv2rgb_decode
// First stage: gray and out-of-range tests, hue wrap, split of the hue into
// sextant and remainder.
// ----------------------------------------------------------------------------
module hsv2rgb_decode (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                in_valid,
   output logic                                in_stall,
   input  logic [hsv2rgb_pkg::HUE_BITS-1:0]    in_hue,
   input  logic [hsv2rgb_pkg::COLOR_BITS-1:0]  in_sat,
   input  logic [hsv2rgb_pkg::COLOR_BITS-1:0]  in_bright,
   output logic                                out_valid,
   input  logic                                out_stall,
   output hsv2rgb_pkg::dec_type                out_data
);
   import hsv2rgb_pkg::*;

   logic                valid_ff;
   logic                valid_in;
   dec_type             data_ff;
   dec_type             data_in;
   logic [HUE_BITS-1:0] hue_w;
   logic [HUE_BITS-1:0] base;

   always_comb begin
      hue_w = (in_hue == HUE_BITS'(HUE_WRAP)) ? '0 : in_hue;
      if (hue_w >= HUE_BITS'(5 * SEXTANT)) begin
         data_in.sextant = SEXT_MAGENTA_RED;
         base = HUE_BITS'(5 * SEXTANT);
      end else if (hue_w >= HUE_BITS'(4 * SEXTANT)) begin
         data_in.sextant = SEXT_BLUE_MAGENTA;
         base = HUE_BITS'(4 * SEXTANT);
      end else if (hue_w >= HUE_BITS'(3 * SEXTANT)) begin
         data_in.sextant = SEXT_CYAN_BLUE;
         base = HUE_BITS'(3 * SEXTANT);
      end else if (hue_w >= HUE_BITS'(2 * SEXTANT)) begin
         data_in.sextant = SEXT_GREEN_CYAN;
         base = HUE_BITS'(2 * SEXTANT);
      end else if (hue_w >= HUE_BITS'(SEXTANT)) begin
         data_in.sextant = SEXT_YELLOW_GREEN;
         base = HUE_BITS'(SEXTANT);
      end else begin
         data_in.sextant = SEXT_RED_YELLOW;
         base = '0;
      end
      data_in.rem    = REM_BITS'(hue_w - base);
      data_in.gray   = (in_sat == '0);
      data_in.black  = (hue_w > HUE_BITS'(HUE_WRAP));
      data_in.sat    = in_sat;
      data_in.bright = in_bright;
   end

   assign in_stall  = valid_ff && out_stall;
   assign valid_in  = in_stall ? valid_ff : in_valid;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!in_stall && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

// File: sv/hsv2rgb_scale.sv
// ----------------------------------------------------------------------------
// hsv2rgb_scale
// Two stages: saturation products, then the brightness-weighted numerators
// of the three levels.
// ----------------------------------------------------------------------------
module hsv2rgb_scale (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_stall,
   input  hsv2rgb_pkg::dec_type in_data,
   output logic                 out_valid,
   input  logic                 out_stall,
   output hsv2rgb_pkg::num_type out_data
);
   import hsv2rgb_pkg::*;

   logic                prod_valid_ff;
   logic                prod_valid_in;
   prod_type            prod_ff;
   prod_type            prod_in;
   logic                prod_stall;
   logic                num_valid_ff;
   logic                num_valid_in;
   num_type             num_ff;
   num_type             num_in;
   logic                num_stall;
   logic [REM_BITS-1:0] crem;

   // stage one: s*r, s*(60-r), full scale minus s
   always_comb begin
      crem             = REM_BITS'(SEXTANT) - in_data.rem;
      prod_in.gray     = in_data.gray;
      prod_in.black    = in_data.black;
      prod_in.sextant  = in_data.sextant;
      prod_in.bright   = in_data.bright;
      prod_in.inv_sat  = FULL_SCALE - in_data.sat;
      prod_in.sat_rem  = SR_BITS'(in_data.sat) * SR_BITS'(in_data.rem);
      prod_in.sat_crem = SR_BITS'(in_data.sat) * SR_BITS'(crem);
   end

   // stage two: numerators
   always_comb begin
      num_in.gray    = prod_ff.gray;
      num_in.black   = prod_ff.black;
      num_in.sextant = prod_ff.sextant;
      num_in.bright  = prod_ff.bright;
      num_in.num_a   = NUMA_BITS'(prod_ff.bright) * NUMA_BITS'(prod_ff.inv_sat);
      num_in.num_b   = NUMB_BITS'(prod_ff.bright) * NUMB_BITS'(DEN_B_SR - prod_ff.sat_rem);
      num_in.num_c   = NUMB_BITS'(prod_ff.bright) * NUMB_BITS'(DEN_B_SR - prod_ff.sat_crem);
   end

   assign num_stall     = num_valid_ff && out_stall;
   assign prod_stall    = prod_valid_ff && num_stall;
   assign in_stall      = prod_stall;
   assign prod_valid_in = prod_stall ? prod_valid_ff : in_valid;
   assign num_valid_in  = num_stall ? num_valid_ff : prod_valid_ff;
   assign out_valid     = num_valid_ff;
   assign out_data      = num_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
         num_valid_ff  <= 1'b0;
      end else begin
         prod_valid_ff <= prod_valid_in;
         num_valid_ff  <= num_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!prod_stall && in_valid) begin
         prod_ff <= prod_in;
      end
      if (!num_stall && prod_valid_ff) begin
         num_ff <= num_in;
      end
   end

endmodule

// File: sv/hsv2rgb_divide.sv
// ----------------------------------------------------------------------------
// hsv2rgb_divide
// Two stages: reciprocal quotient estimates, then one correction step, the
// sextant channel selection and the output register.
// ----------------------------------------------------------------------------
module hsv2rgb_divide (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               in_valid,
   output logic                               in_stall,
   input  hsv2rgb_pkg::num_type               in_data,
   output logic                               out_valid,
   input  logic                               out_stall,
   output logic [hsv2rgb_pkg::COLOR_BITS-1:0] out_red,
   output logic [hsv2rgb_pkg::COLOR_BITS-1:0] out_green,
   output logic [hsv2rgb_pkg::COLOR_BITS-1:0] out_blue
);
   import hsv2rgb_pkg::*;

   localparam int PA_BITS = NUMA_BITS + MA_BITS;
   localparam int PB_BITS = NUMB_BITS + MB_BITS;

   logic                  est_valid_ff;
   logic                  est_valid_in;
   est_type               est_ff;
   est_type               est_in;
   logic                  est_stall;
   logic                  rgb_valid_ff;
   logic                  rgb_valid_in;
   logic [COLOR_BITS-1:0] red_ff;
   logic [COLOR_BITS-1:0] red_in;
   logic [COLOR_BITS-1:0] green_ff;
   logic [COLOR_BITS-1:0] green_in;
   logic [COLOR_BITS-1:0] blue_ff;
   logic [COLOR_BITS-1:0] blue_in;
   logic                  rgb_stall;
   logic [PA_BITS-1:0]    prod_a;
   logic [PB_BITS-1:0]    prod_b;
   logic [PB_BITS-1:0]    prod_c;
   logic [NUMA_BITS-1:0]  rem_a;
   logic [NUMB_BITS-1:0]  rem_b;
   logic [NUMB_BITS-1:0]  rem_c;
   logic [COLOR_BITS-1:0] lvl_a;
   logic [COLOR_BITS-1:0] lvl_b;
   logic [COLOR_BITS-1:0] lvl_c;
   logic [COLOR_BITS-1:0] v;

   // quotient estimate, low by at most one
   always_comb begin
      prod_a         = PA_BITS'(in_data.num_a) * PA_BITS'(RECIP_A);
      prod_b         = PB_BITS'(in_data.num_b) * PB_BITS'(RECIP_B);
      prod_c         = PB_BITS'(in_data.num_c) * PB_BITS'(RECIP_B);
      est_in.gray    = in_data.gray;
      est_in.black   = in_data.black;
      est_in.sextant = in_data.sextant;
      est_in.bright  = in_data.bright;
      est_in.num_a   = in_data.num_a;
      est_in.num_b   = in_data.num_b;
      est_in.num_c   = in_data.num_c;
      est_in.est_a   = prod_a[NUMA_BITS +: COLOR_BITS];
      est_in.est_b   = prod_b[NUMB_BITS +: COLOR_BITS];
      est_in.est_c   = prod_c[NUMB_BITS +: COLOR_BITS];
   end

   // correction and channel routing
   always_comb begin
      rem_a = est_ff.num_a - NUMA_BITS'(est_ff.est_a) * NUMA_BITS'(DEN_A);
      rem_b = est_ff.num_b - NUMB_BITS'(est_ff.est_b) * NUMB_BITS'(DEN_B);
      rem_c = est_ff.num_c - NUMB_BITS'(est_ff.est_c) * NUMB_BITS'(DEN_B);
      lvl_a = est_ff.est_a + COLOR_BITS'(rem_a >= NUMA_BITS'(DEN_A));
      lvl_b = est_ff.est_b + COLOR_BITS'(rem_b >= NUMB_BITS'(DEN_B));
      lvl_c = est_ff.est_c + COLOR_BITS'(rem_c >= NUMB_BITS'(DEN_B));
      v     = est_ff.bright;
      if (est_ff.gray) begin
         red_in   = v;
         green_in = v;
         blue_in  = v;
      end else if (est_ff.black) begin
         red_in   = '0;
         green_in = '0;
         blue_in  = '0;
      end else begin
         case (est_ff.sextant)
            SEXT_RED_YELLOW: begin
               red_in = v;     green_in = lvl_c; blue_in = lvl_a;
            end
            SEXT_YELLOW_GREEN: begin
               red_in = lvl_b; green_in = v;     blue_in = lvl_a;
            end
            SEXT_GREEN_CYAN: begin
               red_in = lvl_a; green_in = v;     blue_in = lvl_c;
            end
            SEXT_CYAN_BLUE: begin
               red_in = lvl_a; green_in = lvl_b; blue_in = v;
            end
            SEXT_BLUE_MAGENTA: begin
               red_in = lvl_c; green_in = lvl_a; blue_in = v;
            end
            default: begin
               red_in = v;     green_in = lvl_a; blue_in = lvl_b;
            end
         endcase
      end
   end

   assign rgb_stall    = rgb_valid_ff && out_stall;
   assign est_stall    = est_valid_ff && rgb_stall;
   assign in_stall     = est_stall;
   assign est_valid_in = est_stall ? est_valid_ff : in_valid;
   assign rgb_valid_in = rgb_stall ? rgb_valid_ff : est_valid_ff;
   assign out_valid    = rgb_valid_ff;
   assign out_red      = red_ff;
   assign out_green    = green_ff;
   assign out_blue     = blue_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         est_valid_ff <= 1'b0;
         rgb_valid_ff <= 1'b0;
      end else begin
         est_valid_ff <= est_valid_in;
         rgb_valid_ff <= rgb_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!est_stall && in_valid) begin
         est_ff <= est_in;
      end
      if (!rgb_stall && est_valid_ff) begin
         red_ff   <= red_in;
         green_ff <= green_in;
         blue_ff  <= blue_in;
      end
   end

endmodule

// File: sv/hsv_to_rgb_converter_core.sv
// throughput: one request per cycle, held back only by rsp_stall
// five register stages: decode, saturation products, numerators,
// reciprocal estimate, correction with output register
// reset clears the stage valid bits only, no data is cleared
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter_core
// Converts hue in degrees, saturation and brightness into red, green and
// blue levels through a stallable five-stage pipeline.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [hsv2rgb_pkg::HUE_BITS-1:0]   req_hue,
   input  logic [hsv2rgb_pkg::COLOR_BITS-1:0] req_saturation,
   input  logic [hsv2rgb_pkg::COLOR_BITS-1:0] req_brightness,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [hsv2rgb_pkg::COLOR_BITS-1:0] rsp_red,
   output logic [hsv2rgb_pkg::COLOR_BITS-1:0] rsp_green,
   output logic [hsv2rgb_pkg::COLOR_BITS-1:0] rsp_blue
);
   import hsv2rgb_pkg::*;

   logic    dec_valid;
   logic    dec_stall;
   dec_type dec_data;
   logic    num_valid;
   logic    num_stall;
   num_type num_data;

   hsv2rgb_decode u_decode (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_stall  (req_stall),
      .in_hue    (req_hue),
      .in_sat    (req_saturation),
      .in_bright (req_brightness),
      .out_valid (dec_valid),
      .out_stall (dec_stall),
      .out_data  (dec_data)
   );

   hsv2rgb_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (dec_valid),
      .in_stall  (dec_stall),
      .in_data   (dec_data),
      .out_valid (num_valid),
      .out_stall (num_stall),
      .out_data  (num_data)
   );

   hsv2rgb_divide u_divide (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (num_valid),
      .in_stall  (num_stall),
      .in_data   (num_data),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_red   (rsp_red),
      .out_green (rsp_green),
      .out_blue  (rsp_blue)
   );

endmodule

// File: sv/hsv2rgb_checker.sv
// ----------------------------------------------------------------------------
// hsv2rgb_checker
// Port-level checks on the converter: reset, stall propagation, latency,
// response hold and request hold.
// ----------------------------------------------------------------------------
module hsv2rgb_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   input  logic                               req_stall,
   input  logic [hsv2rgb_pkg::HUE_BITS-1:0]   req_hue,
   input  logic [hsv2rgb_pkg::COLOR_BITS-1:0] req_saturation,
   input  logic [hsv2rgb_pkg::COLOR_BITS-1:0] req_brightness,
   input  logic                               rsp_valid,
   input  logic                               rsp_stall,
   input  logic [hsv2rgb_pkg::COLOR_BITS-1:0] rsp_red,
   input  logic [hsv2rgb_pkg::COLOR_BITS-1:0] rsp_green,
   input  logic [hsv2rgb_pkg::COLOR_BITS-1:0] rsp_blue
);
   import hsv2rgb_pkg::*;

   // nothing comes out the cycle after reset
   a_reset_empty: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

   // with no response waiting the pipeline can always take a request
   a_no_stall_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("request stalled while output is empty");

   // a request flows through to the response when there is no back-pressure
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) ##1 !rsp_stall ##1 !rsp_stall ##1 !rsp_stall
         ##1 !rsp_stall |=> rsp_valid)
      else $error("response missing after pipeline latency");

   // a stalled response is held
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_red)
         && $stable(rsp_green) && $stable(rsp_blue))
      else $error("stalled response changed");

   // a stalled request is held by the sender
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_hue)
         && $stable(req_saturation) && $stable(req_brightness))
      else $error("stalled request changed");

endmodule

bind hsv_to_rgb_converter_core hsv2rgb_checker u_hsv2rgb_checker (.*);
